// ===== rtl/core/cosine_similarity_best_match_macros.svh =====
`ifndef COSINE_SIMILARITY_BEST_MATCH_MACROS_SVH
`define COSINE_SIMILARITY_BEST_MATCH_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CSBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CSBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/csbm_pkg.sv =====
package csbm_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int ADDR_W     = $clog2(MAX_DIM);
  localparam int LEN_W      = 11;
  localparam int ELEM_W     = 16;
  localparam int IDX_W      = 16;
  localparam int DOT_W      = 42;
  localparam int MAG_W      = 41;
  localparam int ROOT_W     = 21;
  localparam int DEN_W      = 2 * ROOT_W;
  localparam int FRAC_W     = 15;
  localparam int NUM_W      = DOT_W + FRAC_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int CNT_W      = 6;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_DIM);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_SQ_LD_Q,
    S_SQ_Q,
    S_SQ_LD_C,
    S_SQ_C,
    S_DEN,
    S_DIV_LD,
    S_DIV,
    S_FIN
  } csbm_state_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic acc;
    logic sq_load;
    logic sq_src_c;
    logic sq_step;
    logic rq_latch;
    logic den;
    logic div_load;
    logic div_step;
    logic fin;
  } csbm_cmd_t;

  typedef struct packed {
    logic is_cand;
    logic is_final;
    logic out_free;
  } csbm_status_t;

endpackage

// ===== rtl/core/cosine_similarity_best_match.sv =====
// each word is accepted, then passes store read, multiply and accumulate before the next is accepted
// a candidate's final word adds two square roots, a root multiply, a divide and
// a result step, done by the bit-serial square root and restoring divider
// the result waits in an output register; a further finish stalls while it is full and not read
// synchronous active-low reset: vector length 1024, counts, sums and ranking cleared
// query store is not cleared; reading an unwritten entry gives undefined results
module cosine_similarity_best_match
  import csbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ELEM_W-1:0]    in_tdata,   // element
  input  logic                 in_tuser,   // cmd
  input  logic                 in_tlast,   // last_candidate
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [4*IDX_W-1:0]   out_tdata,  // candidate_index, similarity, best_index, best_similarity
  output logic                 out_tlast,  // set_done
  input  logic                 cfg_wr_en,
  input  logic [LEN_W-1:0]     cfg_wr_data
);

  csbm_cmd_t    cmd;
  csbm_status_t status;

  csbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  csbm_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_cmd      (in_tuser),
    .in_element  ($signed(in_tdata)),
    .in_last     (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

// ===== rtl/core/csbm_ctrl.sv =====
module csbm_ctrl
  import csbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  csbm_status_t status,
  output csbm_cmd_t    cmd
);

  csbm_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_RD;
      S_RD:      state_nxt = S_MUL;
      S_MUL:     state_nxt = S_ACC;
      S_ACC:     state_nxt = (status.is_cand && status.is_final) ? S_SQ_LD_Q : S_IDLE;
      S_SQ_LD_Q: begin
        state_nxt = S_SQ_Q;
        cnt_nxt   = '0;
      end
      S_SQ_Q: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_SQ_LD_C;
      end
      S_SQ_LD_C: begin
        state_nxt = S_SQ_C;
        cnt_nxt   = '0;
      end
      S_SQ_C: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_DEN;
      end
      S_DEN:     state_nxt = S_DIV_LD;
      S_DIV_LD: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_FIN;
      end
      S_FIN:     if (status.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_RD:      cmd.mul = 1'b1;
      S_MUL:     cmd.acc = 1'b1;
      S_ACC:     ;
      S_SQ_LD_Q: cmd.sq_load = 1'b1;
      S_SQ_Q:    cmd.sq_step = 1'b1;
      S_SQ_LD_C: begin
        cmd.sq_load  = 1'b1;
        cmd.sq_src_c = 1'b1;
        cmd.rq_latch = 1'b1;
      end
      S_SQ_C:    cmd.sq_step = 1'b1;
      S_DEN:     cmd.den = 1'b1;
      S_DIV_LD:  cmd.div_load = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_FIN:     cmd.fin = status.out_free;
      default:   ;
    endcase
  end

  `include "cosine_similarity_best_match_macros.svh"

  `CSBM_ASSERT_NEXT(a_accept_reads, cmd.accept, state_r == S_RD, "accept not followed by read")
  `CSBM_ASSERT_NOW(a_sq_cnt, state_r == S_SQ_Q || state_r == S_SQ_C, cnt_r < CNT_W'(SQRT_STEPS), "sqrt count overrun")
  `CSBM_ASSERT_NOW(a_div_cnt, state_r == S_DIV, cnt_r < CNT_W'(DIV_STEPS), "divide count overrun")
  `CSBM_ASSERT_NEXT(a_fin_idle, cmd.fin, state_r == S_IDLE, "finish did not return to idle")

endmodule

// ===== rtl/core/csbm_datapath.sv =====
module csbm_datapath
  import csbm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  csbm_cmd_t                cmd,
  output csbm_status_t             status,
  input  logic                     in_cmd,
  input  logic signed [ELEM_W-1:0] in_element,
  input  logic                     in_last,
  input  logic                     cfg_wr_en,
  input  logic [LEN_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [4*IDX_W-1:0]       out_data,
  output logic                     out_last
);

  logic signed [ELEM_W-1:0] qmem [MAX_DIM];

  logic [LEN_W-1:0]          len_r;
  logic [ADDR_W-1:0]         count_r;
  logic signed [ELEM_W-1:0]  e_r, q_r;
  logic                      cand_r, final_r, pos0_r, last_r;
  logic signed [2*ELEM_W-1:0] pdot_r;
  logic [2*ELEM_W-1:0]       psq_r;
  logic signed [DOT_W-1:0]   dot_r;
  logic [MAG_W-1:0]          qmag_r, cmag_r;
  logic [MAG_W-1:0]          sv_r, sroot_r, sbit_r;
  logic [ROOT_W-1:0]         rq_r;
  logic [DEN_W-1:0]          den_r;
  logic [DEN_W-1:0]          rem_r;
  logic [NUM_W-1:0]          quo_r;
  logic                      neg_r;
  logic [IDX_W-1:0]          cidx_r, bidx_r;
  logic signed [ELEM_W-1:0]  bval_r;
  logic                      bvalid_r;
  logic                      ovalid_r;
  logic [4*IDX_W-1:0]        odata_r;
  logic                      olast_r;

  logic [LEN_W-1:0]          eff_len;
  logic                      final_now;
  logic [MAG_W:0]            trial;
  logic [DEN_W:0]            rem_sh;
  logic [DOT_W-1:0]          dot_abs;
  logic signed [ELEM_W-1:0]  sim;
  logic                      take;

  always_comb begin
    if (len_r == '0)                  eff_len = LEN_W'(1);
    else if (len_r > LEN_W'(MAX_DIM)) eff_len = LEN_W'(MAX_DIM);
    else                              eff_len = len_r;
  end

  assign final_now = ({1'b0, count_r} + 1'b1) >= eff_len;

  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= LEN_RESET;
    else if (cfg_wr_en) len_r <= cfg_wr_data;
  end

  // query store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_r <= qmem[count_r];
      if (!in_cmd) qmem[count_r] <= in_element;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      e_r     <= in_element;
      cand_r  <= in_cmd;
      final_r <= final_now;
      pos0_r  <= (count_r == '0);
      last_r  <= in_last;
    end
    if (cmd.mul) begin
      pdot_r <= q_r * e_r;
      psq_r  <= (2*ELEM_W)'(e_r * e_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dot_r   <= '0;
      qmag_r  <= '0;
      cmag_r  <= '0;
    end else begin
      if (cmd.accept) count_r <= final_now ? '0 : count_r + 1'b1;
      if (cmd.acc) begin
        if (!cand_r) begin
          qmag_r <= (pos0_r ? '0 : qmag_r) + MAG_W'(psq_r);
        end else begin
          dot_r  <= (pos0_r ? '0 : dot_r) + DOT_W'(pdot_r);
          cmag_r <= (pos0_r ? '0 : cmag_r) + MAG_W'(psq_r);
        end
      end
    end
  end

  // bit-pair square root, one result bit a cycle
  assign trial = {1'b0, sroot_r} + {1'b0, sbit_r};

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sv_r    <= cmd.sq_src_c ? cmag_r : qmag_r;
      sroot_r <= '0;
      sbit_r  <= MAG_W'(1) << (MAG_W - 1);
    end else if (cmd.sq_step) begin
      if ({1'b0, sv_r} >= trial) begin
        sv_r    <= sv_r - trial[MAG_W-1:0];
        sroot_r <= (sroot_r >> 1) + sbit_r;
      end else begin
        sroot_r <= sroot_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
    if (cmd.rq_latch) rq_r <= sroot_r[ROOT_W-1:0];
    if (cmd.den) den_r <= rq_r * sroot_r[ROOT_W-1:0];
  end

  // restoring divide of |dot| << 15 by the magnitude product
  assign dot_abs = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= '0;
      quo_r <= {dot_abs, {FRAC_W{1'b0}}};
      neg_r <= dot_r[DOT_W-1];
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= DEN_W'(rem_sh - {1'b0, den_r});
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (den_r == '0) begin
      sim = '0;
    end else if (!neg_r) begin
      sim = (quo_r > NUM_W'(32767)) ? 16'sh7fff : $signed(quo_r[ELEM_W-1:0]);
    end else begin
      sim = (quo_r > NUM_W'(32768)) ? 16'sh8000 : $signed(-quo_r[ELEM_W-1:0]);
    end
  end

  assign take = !bvalid_r || (sim > bval_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cidx_r   <= '0;
      bidx_r   <= '0;
      bval_r   <= 16'sh8000;
      bvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      if (cmd.fin) begin
        ovalid_r <= 1'b1;
        if (last_r) begin
          cidx_r   <= '0;
          bidx_r   <= '0;
          bval_r   <= 16'sh8000;
          bvalid_r <= 1'b0;
        end else begin
          cidx_r <= cidx_r + 1'b1;
          if (take) begin
            bidx_r   <= cidx_r;
            bval_r   <= sim;
            bvalid_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      odata_r <= {take ? sim : bval_r, take ? cidx_r : bidx_r, sim, cidx_r};
      olast_r <= last_r;
    end
  end

  assign status.is_cand  = cand_r;
  assign status.is_final = final_r;
  assign status.out_free = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign out_last  = olast_r;

endmodule
